// ===== rtl/ort_pkg.sv =====
package ort_pkg;

  // Fixed widths of the request and result fields.
  localparam int ID_W     = 64;
  localparam int TAG_W    = 16;
  localparam int SEQ_W    = 32;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;
  localparam int USE_W    = 5;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 72;

  // Operation codes carried in the request's tuser.
  typedef enum logic [MODE_W-1:0] {
    OP_ADD  = 2'd0,
    OP_FIND = 2'd1,
    OP_TAKE = 2'd2
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // One table record as it is stored in the slot memory.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [TAG_W-1:0] method;
    logic [TAG_W-1:0] document;
    logic [SEQ_W-1:0] seq_no;
  } slot_t;

  // One result as it leaves the controller.
  typedef struct packed {
    status_t          status;
    logic [TAG_W-1:0] method;
    logic [TAG_W-1:0] document;
    logic [SEQ_W-1:0] seq_no;
    logic [USE_W-1:0] count;
  } res_t;

endpackage

// ===== rtl/ort_ram.sv =====
module ort_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/ort_ctrl.sv =====
module ort_ctrl #(
  parameter int ENTRIES = 16,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Request side
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ort_pkg::MODE_W-1:0]  in_mode,
  input  logic [ort_pkg::ID_W-1:0]    in_key,
  input  logic [ort_pkg::TAG_W-1:0]   in_mtag,
  input  logic [ort_pkg::TAG_W-1:0]   in_dtag,
  // Slot memory
  output logic [IW-1:0]               rd_addr,
  input  ort_pkg::slot_t              rd_data,
  output logic                        wr_en,
  output logic [IW-1:0]               wr_addr,
  output ort_pkg::slot_t              wr_data,
  // Result side
  output logic                        res_valid,
  input  logic                        res_ready,
  output ort_pkg::res_t               res
);

  import ort_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_FIN,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0]   count_r;
  logic [SEQ_W-1:0]   seq_r;

  logic [MODE_W-1:0]  mode_r;
  logic [ID_W-1:0]    key_r;
  logic [TAG_W-1:0]   mtag_r;
  logic [TAG_W-1:0]   dtag_r;
  logic [IW-1:0]      idx_r;
  logic               hit_r;
  logic [IW-1:0]      hit_idx_r;
  slot_t              hit_slot_r;
  logic               free_found_r;
  logic [IW-1:0]      free_idx_r;
  res_t               res_r;

  logic               bad_req;
  logic               add_ok;
  logic               slot_hit;
  logic [CNT_W+4:0]   cnt_same_ext;
  logic [CNT_W+4:0]   cnt_inc_ext;
  logic [CNT_W+4:0]   cnt_dec_ext;

  // Requests that are rejected without touching the table.
  assign bad_req = ((in_mode != OP_ADD) && (in_mode != OP_FIND) && (in_mode != OP_TAKE))
                || (in_key == '0)
                || ((in_mode == OP_ADD) && (in_mtag == '0));

  // Compare of the slot read in the previous cycle.
  assign slot_hit = valid_r[idx_r] && (rd_data.id == key_r);

  // An add lands when the key was absent and a free slot turned up in the scan.
  assign add_ok = (state_r == S_FIN) && (mode_r == OP_ADD) && !hit_r && free_found_r;

  // Entry count as reported, kept to the low five bits.
  assign cnt_same_ext = {5'd0, count_r};
  assign cnt_inc_ext  = {5'd0, count_r + 1'b1};
  assign cnt_dec_ext  = {5'd0, count_r - 1'b1};

  // Memory ports: the scan reads slot by slot, an add writes the new record.
  assign rd_addr = idx_r;
  assign wr_en   = add_ok;
  assign wr_addr = free_idx_r;
  assign wr_data = '{id: key_r, method: mtag_r, document: dtag_r,
                     seq_no: seq_r + 1'b1};

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // Scan sequencer with the valid bits, counters and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      count_r <= '0;
      seq_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r       <= in_mode;
            key_r        <= in_key;
            mtag_r       <= in_mtag;
            dtag_r       <= in_dtag;
            idx_r        <= '0;
            hit_r        <= 1'b0;
            free_found_r <= 1'b0;
            free_idx_r   <= '0;
            if (bad_req) begin
              res_r   <= '{status: ST_INVALID, method: '0, document: '0, seq_no: '0,
                           count: cnt_same_ext[4:0]};
              state_r <= S_DONE;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (slot_hit) begin
            hit_r      <= 1'b1;
            hit_idx_r  <= idx_r;
            hit_slot_r <= rd_data;
            state_r    <= S_FIN;
          end else begin
            // Remember the lowest free slot seen so far.
            if (!valid_r[idx_r] && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= idx_r;
            end
            if (idx_r == LAST_IDX) begin
              state_r <= S_FIN;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (mode_r == OP_ADD) begin
            if (hit_r) begin
              res_r <= '{status: ST_EXISTS, method: '0, document: '0, seq_no: '0,
                         count: cnt_same_ext[4:0]};
            end else if (free_found_r) begin
              valid_r[free_idx_r] <= 1'b1;
              seq_r   <= seq_r + 1'b1;
              count_r <= count_r + 1'b1;
              res_r   <= '{status: ST_OK, method: '0, document: '0, seq_no: '0,
                           count: cnt_inc_ext[4:0]};
            end else begin
              res_r <= '{status: ST_FULL, method: '0, document: '0, seq_no: '0,
                         count: cnt_same_ext[4:0]};
            end
          end else if (hit_r) begin
            if (mode_r == OP_TAKE) begin
              valid_r[hit_idx_r] <= 1'b0;
              count_r <= count_r - 1'b1;
              res_r   <= '{status: ST_OK, method: hit_slot_r.method,
                           document: hit_slot_r.document, seq_no: hit_slot_r.seq_no,
                           count: cnt_dec_ext[4:0]};
            end else begin
              res_r   <= '{status: ST_OK, method: hit_slot_r.method,
                           document: hit_slot_r.document, seq_no: hit_slot_r.seq_no,
                           count: cnt_same_ext[4:0]};
            end
          end else begin
            res_r <= '{status: ST_NOT_FOUND, method: '0, document: '0, seq_no: '0,
                       count: cnt_same_ext[4:0]};
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/outstanding_request_table_core.sv =====
// Table of up to ENTRIES outstanding requests keyed by a nonzero 64-bit id. Each
// request adds, finds, or takes (finds and frees) an entry, and each request yields
// exactly one result with a status and the number of active entries. Records sit in
// a single-port-read slot memory with a registered read, so the lookup walks the
// slots in order, each with a read state and then a compare state. A find, take
// or add whose key is present at slot k stops the scan there; a miss and every
// add whose key is absent scans all slots. Requests rejected as invalid skip the
// scan. The next request is accepted while a finished result still waits in the
// output register. The slot memory needs no clearing after reset.
module outstanding_request_table_core #(
  parameter int ENTRIES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Requests
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [63:0] req_key, [79:64] method_tag, [95:80] document_tag
  input  logic [ort_pkg::IN_DATA_W-1:0]      in_tdata,
  // [1:0] mode
  input  logic [ort_pkg::MODE_W-1:0]         in_tuser,
  // Results
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] found_method, [31:16] found_document, [63:32] found_sequence,
  // [68:64] entries_in_use, [71:69] zero
  output logic [ort_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [2:0] status
  output logic [ort_pkg::STATUS_W-1:0]       out_tuser
);

  import ort_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [IW-1:0] rd_addr;
  slot_t         rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  slot_t         wr_data;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic          out_valid_r;
  res_t          out_res_r;

  // Slot record memory.
  ort_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (ENTRIES)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Lookup and update sequencer.
  ort_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_key    (in_tdata[ID_W-1:0]),
    .in_mtag   (in_tdata[ID_W+TAG_W-1:ID_W]),
    .in_dtag   (in_tdata[ID_W+2*TAG_W-1:ID_W+TAG_W]),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: loads whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_ready) begin
        out_valid_r <= res_valid;
      end
      if (res_valid && res_ready) begin
        out_res_r <= res;
      end
    end
  end

  // Result packing.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {3'b000, out_res_r.count, out_res_r.seq_no,
                       out_res_r.document, out_res_r.method};

`ifndef SYNTHESIS
  // One request at a time: an accepted request makes the table busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while previous one still in progress");

  // A result waiting for the output register keeps the request side closed.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_tready)
    else $error("request side open while a result is pending");

  // Every result with a status other than OK reports an empty record.
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status != ST_OK) |->
      (res.method == '0 && res.document == '0 && res.seq_no == '0))
    else $error("record fields set on a failed request");
`endif

endmodule
